// ===== rtl/rgbled_pkg.sv =====
// Shared types and constants for the three-channel PWM LED core.
// Request payload structs, controller/datapath command and status structs.
// No dependencies.
package rgbled_pkg;

  localparam int CHANNELS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 8;
  localparam int PIN_COUNT     = 3;
  localparam int CFG_W         = 8;
  localparam int TIME_W        = 16;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd20;
  localparam logic [CFG_W-1:0] STEP_RESET   = 8'd10;

  localparam logic [1:0] PAT_NONE   = 2'd0;
  localparam logic [1:0] PAT_FLASH  = 2'd1;
  localparam logic [1:0] PAT_BREATH = 2'd2;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_STEP   = 1'b1;

  typedef struct packed {
    logic              pwm_tick;
    logic [1:0]        pattern;
    logic [2:0]        led_mask;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [TIME_W-1:0] breath_period;
  } in_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

// ===== rtl/rgbled_ctrl.sv =====
// Sequencer for the LED core: accepts a request, runs the divider if needed, commits.
// Depends on rgbled_pkg.
module rgbled_ctrl #(
  parameter int DIV_STEPS = 16 + rgbled_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rgbled_pkg::stat_t  stat,
  output rgbled_pkg::cmd_t   cmd
);
  import rgbled_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.commit   = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.need_div) begin
            state_nxt = S_DIV;
            cnt_nxt   = CNT_W'(DIV_STEPS - 1);
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/rgbled_dp.sv =====
// Datapath of the LED core: config registers, levels, PWM counters,
// flash timer, bit-serial restoring divider for the breath increment.
// Depends on rgbled_pkg.
module rgbled_dp #(
  parameter int CHANNELS  = rgbled_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = rgbled_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rgbled_pkg::in_t                  in_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rgbled_pkg::CFG_W-1:0]     cfg_data,
  input  rgbled_pkg::cmd_t                 cmd,
  output rgbled_pkg::stat_t                stat,
  output rgbled_pkg::out_t                 out_data
);
  import rgbled_pkg::*;

  localparam int LEVEL_BITS = FRAC_BITS + 10;
  localparam int NUM_W      = 2 * CFG_W + FRAC_BITS;
  localparam int SUM_W      = ((LEVEL_BITS > NUM_W) ? LEVEL_BITS : NUM_W) + 2;
  localparam int TMR_W      = TIME_W + 1;

  localparam logic signed [SUM_W-1:0] LMAX_EXT =
    {{(SUM_W-LEVEL_BITS+1){1'b0}}, {(LEVEL_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] LMIN_EXT =
    {{(SUM_W-LEVEL_BITS+1){1'b1}}, {(LEVEL_BITS-1){1'b0}}};
  localparam logic signed [LEVEL_BITS-1:0] LMAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
  localparam logic signed [LEVEL_BITS-1:0] LMIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

  logic [CFG_W-1:0]  period_r, step_r;
  in_t               item_r;
  logic [NUM_W-1:0]  quo_r;
  logic [TIME_W-1:0] rem_r;
  logic [CFG_W-1:0]  count_r [CHANNELS];
  logic signed [LEVEL_BITS-1:0] level_r [CHANNELS];
  logic [CHANNELS-1:0] ramp_r;
  logic [TMR_W-1:0]  timer_r;
  out_t              pins_r;

  logic [2*CFG_W-1:0] prod;
  logic [NUM_W-1:0]   num;
  logic [TIME_W:0]    trial, diff;
  logic               ge;

  logic [CHANNELS+2:0] mask_ext;
  logic                on_phase;
  logic signed [LEVEL_BITS-1:0] full_lvl;
  logic signed [SUM_W-1:0]      delta_ext;
  logic signed [SUM_W-1:0]      sum_c   [CHANNELS];
  logic signed [LEVEL_BITS-1:0] sat_c   [CHANNELS];
  logic signed [LEVEL_BITS-1:0] lvl_nxt [CHANNELS];
  logic [CHANNELS-1:0]          ramp_nxt;
  logic [CHANNELS-1:0]          pin_c;
  logic [CHANNELS+2:0]          pin_ext;
  logic [CFG_W:0]               cnt_inc [CHANNELS];
  logic [CFG_W-1:0]             cnt_nxt [CHANNELS];
  logic [TMR_W:0]               tsum;
  logic [TMR_W-1:0]             tlim, timer_nxt;
  out_t                         pins_nxt;

  assign prod = period_r * step_r;
  assign num  = {prod, {FRAC_BITS{1'b0}}};

  assign stat.need_div = (in_data.pattern == PAT_BREATH) && (in_data.breath_period != '0);

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, item_r.breath_period};
  assign diff  = trial - {1'b0, item_r.breath_period};

  always_comb begin
    mask_ext  = {{CHANNELS{1'b0}}, item_r.led_mask};
    on_phase  = timer_r < {1'b0, item_r.on_time};
    full_lvl  = {2'b00, period_r, {FRAC_BITS{1'b0}}};
    delta_ext = {{(SUM_W-NUM_W){1'b0}}, quo_r};
    tsum      = {1'b0, timer_r} + {{(TMR_W+1-CFG_W){1'b0}}, step_r};
    tlim      = {1'b0, item_r.on_time} + {1'b0, item_r.off_time};
    timer_nxt = (tsum >= {1'b0, tlim}) ? '0 : tsum[TMR_W-1:0];
    for (int c = 0; c < CHANNELS; c++) begin
      sum_c[c] = ramp_r[c]
        ? ({{(SUM_W-LEVEL_BITS){level_r[c][LEVEL_BITS-1]}}, level_r[c]} - delta_ext)
        : ({{(SUM_W-LEVEL_BITS){level_r[c][LEVEL_BITS-1]}}, level_r[c]} + delta_ext);
      if (sum_c[c] > LMAX_EXT) begin
        sat_c[c] = LMAX;
      end else if (sum_c[c] < LMIN_EXT) begin
        sat_c[c] = LMIN;
      end else begin
        sat_c[c] = sum_c[c][LEVEL_BITS-1:0];
      end
      lvl_nxt[c]  = level_r[c];
      ramp_nxt[c] = ramp_r[c];
      case (item_r.pattern)
        PAT_FLASH: begin
          lvl_nxt[c] = (on_phase && mask_ext[c]) ? full_lvl : '0;
        end
        PAT_BREATH: begin
          if (!mask_ext[c]) begin
            lvl_nxt[c] = '0;
          end else begin
            lvl_nxt[c] = sat_c[c];
            if (!ramp_r[c]) begin
              if (sat_c[c] > full_lvl) ramp_nxt[c] = 1'b1;
            end else begin
              if (sat_c[c] < 0) ramp_nxt[c] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      pin_c[c]   = lvl_nxt[c] > $signed({2'b00, count_r[c], {FRAC_BITS{1'b0}}});
      cnt_inc[c] = {1'b0, count_r[c]} + {{CFG_W{1'b0}}, 1'b1};
      cnt_nxt[c] = (cnt_inc[c] >= {1'b0, period_r}) ? '0 : cnt_inc[c][CFG_W-1:0];
    end
    pin_ext           = {3'b000, pin_c};
    pins_nxt.red_on   = pin_ext[0];
    pins_nxt.green_on = pin_ext[1];
    pins_nxt.blue_on  = pin_ext[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      step_r   <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD: period_r <= cfg_data;
        CFG_STEP:   step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      rem_r  <= '0;
      quo_r  <= stat.need_div ? num : '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_r  <= {quo_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        count_r[c] <= '0;
        level_r[c] <= (c == 1) ? {2'b00, PERIOD_RESET, {FRAC_BITS{1'b0}}} : '0;
      end
      ramp_r  <= '0;
      timer_r <= '0;
      pins_r  <= '0;
    end else if (cmd.commit) begin
      for (int c = 0; c < CHANNELS; c++) begin
        level_r[c] <= lvl_nxt[c];
        if (item_r.pwm_tick) count_r[c] <= cnt_nxt[c];
      end
      ramp_r <= ramp_nxt;
      if (item_r.pattern == PAT_FLASH) timer_r <= timer_nxt;
      if (item_r.pwm_tick) pins_r <= pins_nxt;
    end
  end

  assign out_data = pins_r;

endmodule

// ===== rtl/rgb_led_pwm_breath_flash_core.sv =====
// Three-channel PWM LED core with flash and breath patterns.
// Instantiates rgbled_ctrl and rgbled_dp; depends on rgbled_pkg.
//
// Each request produces exactly one result holding the three pin levels. A breath
// step with a nonzero breath_period first runs the bit-serial divider, which works
// out the breath increment one quotient bit per cycle; other requests skip it. The
// result sits in an output register; the next request is accepted while it waits,
// and completes once the pending result has been taken. Configuration writes take
// effect at once, also on a request in flight.
module rgb_led_pwm_breath_flash_core #(
  parameter int CHANNELS  = rgbled_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = rgbled_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rgbled_pkg::in_t              in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rgbled_pkg::out_t             out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rgbled_pkg::CFG_W-1:0] cfg_data
);
  import rgbled_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rgbled_ctrl #(
    .DIV_STEPS(2 * CFG_W + FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rgbled_dp #(
    .CHANNELS (CHANNELS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a request in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over an untaken result");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.commit}))
    else $error("conflicting datapath commands");

endmodule
